// ----- design/mfu_pkg.sv -----
// Package for the MIPS frame unwind interval scanner.
// Holds opcode and register codes and the result record type.
// No dependencies.
`default_nettype none

package mfu_pkg;

  // major opcodes
  localparam logic [5:0] OP_SPECIAL = 6'h00;
  localparam logic [5:0] OP_ADDI    = 6'h08;
  localparam logic [5:0] OP_ADDIU   = 6'h09;
  localparam logic [5:0] OP_DADDI   = 6'h18;
  localparam logic [5:0] OP_DADDIU  = 6'h19;
  localparam logic [5:0] OP_LW      = 6'h23;
  localparam logic [5:0] OP_SW      = 6'h2B;
  localparam logic [5:0] OP_LD      = 6'h37;
  localparam logic [5:0] OP_SD      = 6'h3F;

  localparam logic [5:0] FUNCT_JR   = 6'h08;

  localparam logic [4:0] REG_SP = 5'd29;
  localparam logic [4:0] REG_RA = 5'd31;

  localparam logic KIND_INTERVAL   = 1'b0;
  localparam logic KIND_REGION_END = 1'b1;

  localparam int unsigned MAX_RESULTS = 3;

  typedef struct packed {
    logic        kind;
    logic [16:0] start;
    logic [23:0] frame;
    logic        inreg;
    logic [23:0] loc;
  } result_t;

endpackage

`default_nettype wire

// ----- design/mips_frame_unwind_interval_scanner_core.sv -----
// Top level of the MIPS frame unwind interval scanner.
// Input register, tracked state, step logic and result buffer.
// Depends on mfu_pkg, mfu_step, mfu_result_buf.
//
//   channel | handshake            | payload
//   --------+----------------------+-----------------------------------------------
//   in      | in_valid / in_stall  | insn_word, word_index, words_remaining
//   out     | out_valid / out_stall| result_kind, start_index, frame_size,
//           |                      | ra_in_register, ra_location, last_of_run
//
// One word per cycle enters the input register unless in_stall is set; results
// leave one transaction per cycle from the result buffer unless out_stall is set.
// A word with k results (1 to 3) holds the buffer until all k are taken, so the
// next word waits in the input register; words with no result pass at one per
// cycle. Words flow input register, result buffer. Sync reset, no clearing pass.
`default_nettype none

module mips_frame_unwind_interval_scanner_core
  import mfu_pkg::*;
#(
  parameter int OFFSET_BITS = 24
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [31:0] insn_word,
  input  wire logic [15:0] word_index,
  input  wire logic [16:0] words_remaining,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic             result_kind,
  output logic      [16:0] start_index,
  output logic      [23:0] frame_size,
  output logic             ra_in_register,
  output logic      [23:0] ra_location,
  output logic             last_of_run
);

  localparam logic [OFFSET_BITS-1:0] RA_LOC = {{(OFFSET_BITS-5){1'b0}}, REG_RA};

  logic        iv;
  logic [31:0] i_insn;
  logic [15:0] i_idx;
  logic [16:0] i_rem;
  logic        load, can_load;

  logic [OFFSET_BITS-1:0] cur_fs, cur_loc, canon_fs, canon_loc;
  logic                   cur_inreg, canon_inreg, canon_cap;
  logic [OFFSET_BITS-1:0] cur_fs_next, cur_loc_next, canon_fs_next, canon_loc_next;
  logic                   cur_inreg_next, canon_inreg_next, canon_cap_next;

  result_t    res [MAX_RESULTS];
  logic [1:0] res_count;

  assign load     = iv && can_load;
  assign in_stall = iv && !can_load;

  always_ff @(posedge clk) begin
    if (rst) begin
      iv <= 1'b0;
    end else if (!in_stall) begin
      iv <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      i_insn <= insn_word;
      i_idx  <= word_index;
      i_rem  <= words_remaining;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_fs      <= '0;
      cur_inreg   <= 1'b1;
      cur_loc     <= RA_LOC;
      canon_fs    <= '0;
      canon_inreg <= 1'b1;
      canon_loc   <= RA_LOC;
      canon_cap   <= 1'b0;
    end else if (load) begin
      cur_fs      <= cur_fs_next;
      cur_inreg   <= cur_inreg_next;
      cur_loc     <= cur_loc_next;
      canon_fs    <= canon_fs_next;
      canon_inreg <= canon_inreg_next;
      canon_loc   <= canon_loc_next;
      canon_cap   <= canon_cap_next;
    end
  end

  mfu_step #(
    .OFFSET_BITS(OFFSET_BITS)
  ) u_step (
    .insn_word       (i_insn),
    .word_index      (i_idx),
    .words_remaining (i_rem),
    .cur_fs          (cur_fs),
    .cur_inreg       (cur_inreg),
    .cur_loc         (cur_loc),
    .canon_fs        (canon_fs),
    .canon_inreg     (canon_inreg),
    .canon_loc       (canon_loc),
    .canon_cap       (canon_cap),
    .nxt_fs          (cur_fs_next),
    .nxt_inreg       (cur_inreg_next),
    .nxt_loc         (cur_loc_next),
    .nxt_canon_fs    (canon_fs_next),
    .nxt_canon_inreg (canon_inreg_next),
    .nxt_canon_loc   (canon_loc_next),
    .nxt_canon_cap   (canon_cap_next),
    .res             (res),
    .res_count       (res_count)
  );

  mfu_result_buf u_buf (
    .clk            (clk),
    .rst            (rst),
    .load           (load),
    .res            (res),
    .res_count      (res_count),
    .can_load       (can_load),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .result_kind    (result_kind),
    .start_index    (start_index),
    .frame_size     (frame_size),
    .ra_in_register (ra_in_register),
    .ra_location    (ra_location),
    .last_of_run    (last_of_run)
  );

  // an empty result buffer never holds back the input side
  a_empty_no_stall: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> !in_stall)
    else $error("input stalled while result buffer empty");

  // canonical state is only ever taken from a store of ra
  a_canon_in_frame: assert property (@(posedge clk) disable iff (rst)
    canon_cap |-> !canon_inreg)
    else $error("captured canonical state has ra in register");

  a_ra_reg_loc: assert property (@(posedge clk) disable iff (rst)
    cur_inreg |-> cur_loc == RA_LOC)
    else $error("ra in register but location is not 31");

  // state changes only when a word moves into the result buffer
  a_state_on_load: assert property (@(posedge clk) disable iff (rst)
    !load |=> $stable(cur_fs) && $stable(canon_cap))
    else $error("tracked state changed without a word being processed");

endmodule

`default_nettype wire

// ----- design/mfu_step.sv -----
// Per-word decode and unwind state update for the interval scanner.
// Produces up to three result records and the next tracked state.
// Depends on mfu_pkg.
`default_nettype none

module mfu_step
  import mfu_pkg::*;
#(
  parameter int OFFSET_BITS = 24
) (
  input  wire logic [31:0]            insn_word,
  input  wire logic [15:0]            word_index,
  input  wire logic [16:0]            words_remaining,
  input  wire logic [OFFSET_BITS-1:0] cur_fs,
  input  wire logic                   cur_inreg,
  input  wire logic [OFFSET_BITS-1:0] cur_loc,
  input  wire logic [OFFSET_BITS-1:0] canon_fs,
  input  wire logic                   canon_inreg,
  input  wire logic [OFFSET_BITS-1:0] canon_loc,
  input  wire logic                   canon_cap,
  output logic      [OFFSET_BITS-1:0] nxt_fs,
  output logic                        nxt_inreg,
  output logic      [OFFSET_BITS-1:0] nxt_loc,
  output logic      [OFFSET_BITS-1:0] nxt_canon_fs,
  output logic                        nxt_canon_inreg,
  output logic      [OFFSET_BITS-1:0] nxt_canon_loc,
  output logic                        nxt_canon_cap,
  output result_t                     res [MAX_RESULTS],
  output logic      [1:0]             res_count
);

  localparam int SW = OFFSET_BITS + 2;
  localparam logic [OFFSET_BITS-1:0] RA_LOC = {{(OFFSET_BITS-5){1'b0}}, REG_RA};

  function automatic logic [23:0] to_out(input logic [OFFSET_BITS-1:0] v);
    logic [OFFSET_BITS+23:0] ext;
    ext = {{24{v[OFFSET_BITS-1]}}, v};
    return ext[23:0];
  endfunction

  // clamp a wide sum to OFFSET_BITS signed
  function automatic logic [OFFSET_BITS-1:0] sat(input logic [SW-1:0] v);
    logic fits;
    fits = (v[SW-1:OFFSET_BITS-1] == {3{v[SW-1]}});
    if (fits)
      return v[OFFSET_BITS-1:0];
    else if (v[SW-1])
      return {1'b1, {(OFFSET_BITS-1){1'b0}}};
    else
      return {1'b0, {(OFFSET_BITS-1){1'b1}}};
  endfunction

  function automatic result_t mk(input logic kind, input logic [16:0] start,
                                 input logic [OFFSET_BITS-1:0] fs, input logic inreg,
                                 input logic [OFFSET_BITS-1:0] loc);
    result_t r;
    r.kind  = kind;
    r.start = start;
    r.frame = to_out(fs);
    r.inreg = inreg;
    r.loc   = to_out(loc);
    return r;
  endfunction

  logic [5:0]  op, funct;
  logic [4:0]  rs, rt;
  logic [15:0] imm;
  logic [16:0] amnt;
  logic [16:0] idx_p1, idx_p2;
  logic        is_adj, is_store, is_load, is_ret, differs;
  logic [OFFSET_BITS-1:0] b_fs, b_loc, b_cfs, b_cloc;
  logic        b_inreg, b_cinreg, b_cap;
  logic [1:0]  n;

  assign op     = insn_word[31:26];
  assign rs     = insn_word[25:21];
  assign rt     = insn_word[20:16];
  assign funct  = insn_word[5:0];
  assign imm    = insn_word[15:0];
  assign amnt   = 17'd0 - {imm[15], imm};
  assign idx_p1 = {1'b0, word_index} + 17'd1;
  assign idx_p2 = {1'b0, word_index} + 17'd2;

  assign is_adj   = (op == OP_ADDI || op == OP_ADDIU || op == OP_DADDI || op == OP_DADDIU)
                    && rs == REG_SP && rt == REG_SP;
  assign is_store = (op == OP_SW || op == OP_SD) && rs == REG_SP && rt == REG_RA;
  assign is_load  = (op == OP_LW || op == OP_LD) && rs == REG_SP && rt == REG_RA;
  assign is_ret   = op == OP_SPECIAL && funct == FUNCT_JR && rs == REG_RA
                    && words_remaining > 17'd2;

  // word index 0 restarts from the reset picture
  always_comb begin
    if (word_index == 16'd0) begin
      b_fs = '0; b_inreg = 1'b1; b_loc = RA_LOC;
      b_cfs = '0; b_cinreg = 1'b1; b_cloc = RA_LOC; b_cap = 1'b0;
    end else begin
      b_fs = cur_fs; b_inreg = cur_inreg; b_loc = cur_loc;
      b_cfs = canon_fs; b_cinreg = canon_inreg; b_cloc = canon_loc; b_cap = canon_cap;
    end
  end

  assign differs = (b_fs != b_cfs) || (b_inreg != b_cinreg) || (b_loc != b_cloc);

  always_comb begin
    nxt_fs = b_fs; nxt_inreg = b_inreg; nxt_loc = b_loc;
    nxt_canon_fs = b_cfs; nxt_canon_inreg = b_cinreg; nxt_canon_loc = b_cloc;
    nxt_canon_cap = b_cap;
    for (int i = 0; i < MAX_RESULTS; i++) res[i] = '0;
    n = 2'd0;

    if (word_index == 16'd0) begin
      res[n] = mk(KIND_INTERVAL, 17'd0, b_fs, b_inreg, b_loc);
      n = n + 2'd1;
    end

    if (is_adj) begin
      nxt_fs = sat({{2{b_fs[OFFSET_BITS-1]}}, b_fs}
                   + {{(SW-17){amnt[16]}}, amnt});
      if (!b_inreg)
        nxt_loc = sat({{2{b_loc[OFFSET_BITS-1]}}, b_loc}
                      + {{(SW-17){amnt[16]}}, amnt});
      res[n] = mk(KIND_INTERVAL, idx_p1, nxt_fs, nxt_inreg, nxt_loc);
      n = n + 2'd1;
    end else if (is_store) begin
      nxt_inreg = 1'b0;
      nxt_loc   = {{(OFFSET_BITS-16){imm[15]}}, imm};
      res[n] = mk(KIND_INTERVAL, idx_p1, nxt_fs, nxt_inreg, nxt_loc);
      n = n + 2'd1;
      if (!b_cap) begin
        nxt_canon_cap   = 1'b1;
        nxt_canon_fs    = nxt_fs;
        nxt_canon_inreg = 1'b0;
        nxt_canon_loc   = nxt_loc;
      end
    end else if (is_load) begin
      nxt_inreg = 1'b1;
      nxt_loc   = RA_LOC;
      res[n] = mk(KIND_INTERVAL, idx_p1, nxt_fs, nxt_inreg, nxt_loc);
      n = n + 2'd1;
    end else if (is_ret && differs) begin
      // interior return: canonical picture holds again after the delay slot
      nxt_fs = b_cfs; nxt_inreg = b_cinreg; nxt_loc = b_cloc;
      res[n] = mk(KIND_INTERVAL, idx_p2, nxt_fs, nxt_inreg, nxt_loc);
      n = n + 2'd1;
    end

    if (words_remaining <= 17'd1) begin
      res[n] = mk(KIND_REGION_END, idx_p1, nxt_fs, nxt_inreg, nxt_loc);
      n = n + 2'd1;
    end
  end

  assign res_count = n;

endmodule

`default_nettype wire

// ----- design/mfu_result_buf.sv -----
// Result buffer for the interval scanner: holds the records of one word
// and hands one out per cycle while out_stall is low. Depends on mfu_pkg.
`default_nettype none

module mfu_result_buf
  import mfu_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        load,
  input  wire result_t     res [MAX_RESULTS],
  input  wire logic [1:0]  res_count,
  output logic             can_load,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic             result_kind,
  output logic      [16:0] start_index,
  output logic      [23:0] frame_size,
  output logic             ra_in_register,
  output logic      [23:0] ra_location,
  output logic             last_of_run
);

  result_t    entries [MAX_RESULTS];
  logic [1:0] num, pos;
  logic       taking;
  result_t    cur;

  assign out_valid   = num != 2'd0;
  assign taking      = out_valid && !out_stall;
  assign last_of_run = pos == num - 2'd1;
  assign can_load    = !out_valid || (taking && last_of_run);

  always_ff @(posedge clk) begin
    if (rst) begin
      num <= 2'd0;
      pos <= 2'd0;
    end else if (load) begin
      num <= res_count;
      pos <= 2'd0;
    end else if (taking) begin
      if (last_of_run) begin
        num <= 2'd0;
        pos <= 2'd0;
      end else begin
        pos <= pos + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      for (int i = 0; i < MAX_RESULTS; i++) entries[i] <= res[i];
    end
  end

  always_comb begin
    case (pos)
      2'd0:    cur = entries[0];
      2'd1:    cur = entries[1];
      default: cur = entries[2];
    endcase
  end

  assign result_kind    = cur.kind;
  assign start_index    = cur.start;
  assign frame_size     = cur.frame;
  assign ra_in_register = cur.inreg;
  assign ra_location    = cur.loc;

endmodule

`default_nettype wire

// ----- bench/testbench.sv -----
// Self-checking bench for mips_frame_unwind_interval_scanner_core.
// Scoreboard class predicts unwind intervals per accepted word; tasks drive
// both valid/stall channels. Depends on mfu_pkg and the core RTL.
`timescale 1ns / 1ps

module testbench;
  import mfu_pkg::*;

  localparam int MAX_REGION_WORDS = 65536;
  localparam int OFF_MAX = (1 << 23) - 1;
  localparam int OFF_MIN = -(1 << 23);
  localparam int RANDOM_WORDS = 16;
  localparam int QUIET_WORDS = 8;
  localparam int DEEP_WORDS = 264;

  // encodings that sit next to the decoded ones but must be ignored
  localparam logic [5:0] OP_SWL     = 6'h2A;
  localparam logic [5:0] FUNCT_JALR = 6'h09;

  typedef struct packed {
    result_t r;
    logic    last;
  } interval_t;

  class interval_scoreboard;
    logic signed [23:0] frame, ra_loc, canon_frame, canon_loc;
    logic               ra_inreg, canon_inreg, canon_taken;
    interval_t          pending_intervals[$];
    int                 errors;

    function new();
      errors = 0;
      restart_scan();
    endfunction

    function void restart_scan();
      frame       = '0;
      ra_inreg    = 1'b1;
      ra_loc      = 24'(REG_RA);
      canon_frame = '0;
      canon_inreg = 1'b1;
      canon_loc   = 24'(REG_RA);
      canon_taken = 1'b0;
    endfunction

    function logic signed [23:0] clamp24(int v);
      if (v > OFF_MAX) return 24'(OFF_MAX);
      if (v < OFF_MIN) return 24'(OFF_MIN);
      return 24'(v);
    endfunction

    function interval_t make_rec(logic kind, int start);
      interval_t rec;
      rec.r.kind  = kind;
      rec.r.start = 17'(start);
      rec.r.frame = frame;
      rec.r.inreg = ra_inreg;
      rec.r.loc   = ra_loc;
      rec.last    = 1'b0;
      return rec;
    endfunction

    // Advance the tracked frame state by one word and queue its intervals.
    function void note_word(logic [31:0] insn, logic [15:0] idx, logic [16:0] remaining);
      interval_t  outs[3];
      int         n, rem, imm, amnt, i;
      logic [5:0] op;
      logic [4:0] rs, rt;
      n   = 0;
      rem = int'(remaining);
      if (rem > MAX_REGION_WORDS) rem = MAX_REGION_WORDS;
      op  = insn[31:26];
      rs  = insn[25:21];
      rt  = insn[20:16];
      imm = int'($signed(insn[15:0]));
      if (idx == 16'd0) begin
        restart_scan();
        outs[n] = make_rec(KIND_INTERVAL, 0);
        n++;
      end
      if ((op == OP_ADDI || op == OP_ADDIU || op == OP_DADDI || op == OP_DADDIU) &&
          rs == REG_SP && rt == REG_SP) begin
        amnt  = -imm;
        frame = clamp24(int'(frame) + amnt);
        if (!ra_inreg) ra_loc = clamp24(int'(ra_loc) + amnt);
        outs[n] = make_rec(KIND_INTERVAL, int'(idx) + 1);
        n++;
      end else if ((op == OP_SW || op == OP_SD) && rs == REG_SP && rt == REG_RA) begin
        ra_inreg = 1'b0;
        ra_loc   = clamp24(imm);
        outs[n]  = make_rec(KIND_INTERVAL, int'(idx) + 1);
        n++;
        if (!canon_taken) begin
          canon_taken = 1'b1;
          canon_frame = frame;
          canon_inreg = ra_inreg;
          canon_loc   = ra_loc;
        end
      end else if ((op == OP_LW || op == OP_LD) && rs == REG_SP && rt == REG_RA) begin
        ra_inreg = 1'b1;
        ra_loc   = 24'(REG_RA);
        outs[n]  = make_rec(KIND_INTERVAL, int'(idx) + 1);
        n++;
      end else if (op == OP_SPECIAL && insn[5:0] == FUNCT_JR && rs == REG_RA && rem > 2) begin
        // interior return: fall back to the first post-store state
        if (frame != canon_frame || ra_inreg != canon_inreg || ra_loc != canon_loc) begin
          frame    = canon_frame;
          ra_inreg = canon_inreg;
          ra_loc   = canon_loc;
          outs[n]  = make_rec(KIND_INTERVAL, int'(idx) + 2);
          n++;
        end
      end
      if (rem <= 1) begin
        outs[n] = make_rec(KIND_REGION_END, int'(idx) + 1);
        n++;
      end
      if (n > 0) outs[n - 1].last = 1'b1;
      for (i = 0; i < n; i++) pending_intervals.push_back(outs[i]);
    endfunction

    task report(string msg);
      errors++;
      if (errors <= 100) $display("MISMATCH @%0t: %s", $time, msg);
    endtask

    task check_result(logic kind, logic [16:0] start, logic [23:0] frame_o,
                      logic inreg_o, logic [23:0] loc_o, logic last_o);
      interval_t e;
      if (pending_intervals.size() == 0) begin
        report($sformatf("unexpected transaction kind=%0d start=%0d", kind, start));
        return;
      end
      e = pending_intervals.pop_front();
      if (kind !== e.r.kind)
        report($sformatf("result_kind %0d, want %0d (start %0d)", kind, e.r.kind, e.r.start));
      if (start !== e.r.start)
        report($sformatf("start_index %0d, want %0d", start, e.r.start));
      if (frame_o !== e.r.frame)
        report($sformatf("frame_size %0d, want %0d (start %0d)",
                         $signed(frame_o), $signed(e.r.frame), e.r.start));
      if (inreg_o !== e.r.inreg)
        report($sformatf("ra_in_register %0d, want %0d (start %0d)",
                         inreg_o, e.r.inreg, e.r.start));
      if (loc_o !== e.r.loc)
        report($sformatf("ra_location %0d, want %0d (start %0d)",
                         $signed(loc_o), $signed(e.r.loc), e.r.start));
      if (last_o !== e.last)
        report($sformatf("last_of_run %0d, want %0d (start %0d)", last_o, e.last, e.r.start));
    endtask

    task flush_leftovers();
      interval_t e;
      while (pending_intervals.size() != 0) begin
        e = pending_intervals.pop_front();
        report($sformatf("missing transaction kind=%0d start=%0d", e.r.kind, e.r.start));
      end
    endtask
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic [31:0] insn_word = '0;
  logic [15:0] word_index = '0;
  logic [16:0] words_remaining = 17'd1;
  logic        out_stall = 1'b0;
  wire         in_stall, out_valid;
  wire         result_kind, ra_in_register, last_of_run;
  wire  [16:0] start_index;
  wire  [23:0] frame_size, ra_location;

  interval_scoreboard sb;
  bit idle_on = 1'b1;
  int stall_left = 0;
  int words_sent = 0;

  mips_frame_unwind_interval_scanner_core dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .insn_word(insn_word), .word_index(word_index), .words_remaining(words_remaining),
    .out_valid(out_valid), .out_stall(out_stall),
    .result_kind(result_kind), .start_index(start_index), .frame_size(frame_size),
    .ra_in_register(ra_in_register), .ra_location(ra_location), .last_of_run(last_of_run)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  initial begin
    #20_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  // receiver back-pressure in random bursts
  always @(negedge clk) begin
    if (!idle_on) begin
      stall_left = 0;
      out_stall <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else if ($urandom_range(0, 7) == 0) begin
      stall_left = $urandom_range(1, 15) - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall)
      sb.check_result(result_kind, start_index, frame_size, ra_in_register,
                      ra_location, last_of_run);
  end

  function automatic logic [31:0] itype(logic [5:0] op, logic [4:0] rs, logic [4:0] rt,
                                        logic [15:0] imm);
    return {op, rs, rt, imm};
  endfunction

  function automatic logic [31:0] rtype(logic [4:0] rs, logic [5:0] funct);
    logic [14:0] mid;
    mid = 15'($urandom);
    return {OP_SPECIAL, rs, mid, funct};
  endfunction

  function automatic logic [31:0] body_word(int frame_bytes);
    logic [5:0]  adj_ops[4];
    logic [15:0] imm;
    adj_ops = '{OP_ADDI, OP_ADDIU, OP_DADDI, OP_DADDIU};
    imm = ($urandom_range(0, 1) == 0) ? 16'(frame_bytes - 4) : 16'($urandom);
    case ($urandom_range(0, 11))
      0, 1:    return itype(adj_ops[$urandom_range(0, 3)], REG_SP, REG_SP, 16'($urandom));
      2:       return itype($urandom_range(0, 1) ? OP_SW : OP_SD, REG_SP, REG_RA, imm);
      3:       return itype($urandom_range(0, 1) ? OP_LW : OP_LD, REG_SP, REG_RA, imm);
      4, 5:    return rtype(REG_RA, FUNCT_JR);
      // near misses: right opcode, wrong register, or wrong funct
      6:       return itype(adj_ops[$urandom_range(0, 3)], REG_SP, 5'($urandom), imm);
      7:       return itype(OP_SW, 5'($urandom), REG_RA, imm);
      8:       return rtype(5'($urandom), 6'($urandom));
      default: return $urandom;
    endcase
  endfunction

  task automatic send_word(logic [31:0] w, logic [15:0] idx, logic [16:0] rem);
    int gap;
    gap = (idle_on && $urandom_range(0, 5) == 0) ? $urandom_range(1, 15) : 0;
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid        <= 1'b1;
    insn_word       <= w;
    word_index      <= idx;
    words_remaining <= rem;
    do @(posedge clk); while (in_stall);
    sb.note_word(w, idx, rem);
    words_sent++;
  endtask

  // prologue, random body, epilogue; occasionally broken
  task automatic run_procedure(int len);
    int          i, frame_bytes;
    logic [31:0] w;
    logic [15:0] idx;
    frame_bytes = 8 * $urandom_range(1, 64);
    for (i = 0; i < len; i++) begin
      if (i == 0)
        w = itype(OP_ADDIU, REG_SP, REG_SP, 16'(-frame_bytes));
      else if (i == 1)
        w = itype($urandom_range(0, 1) ? OP_SW : OP_SD, REG_SP, REG_RA, 16'(frame_bytes - 4));
      else if (i == len - 4)
        w = itype($urandom_range(0, 1) ? OP_LW : OP_LD, REG_SP, REG_RA, 16'(frame_bytes - 4));
      else if (i == len - 3)
        w = itype(OP_ADDIU, REG_SP, REG_SP, 16'(frame_bytes));
      else if (i == len - 2)
        w = rtype(REG_RA, FUNCT_JR);
      else
        w = body_word(frame_bytes);
      if ($urandom_range(0, 9) == 0) w = body_word(frame_bytes);
      idx = ($urandom_range(0, 24) == 0) ? 16'($urandom) : 16'(i);
      send_word(w, idx, 17'(len - i));
    end
  endtask

  task automatic send_noise();
    logic [16:0] rem;
    logic [15:0] idx;
    rem = ($urandom_range(0, 7) == 0) ? 17'($urandom_range(MAX_REGION_WORDS + 1, 131071))
                                      : 17'($urandom_range(1, MAX_REGION_WORDS));
    idx = ($urandom_range(0, 1) == 0) ? 16'($urandom) : 16'($urandom_range(0, 31));
    send_word($urandom, idx, rem);
  endtask

  // long run of stack adjusts to drive frame size and ra offset into saturation
  task automatic run_deep_frame(logic [15:0] step_imm);
    logic [5:0] adj_ops[4];
    int         i;
    adj_ops = '{OP_ADDI, OP_ADDIU, OP_DADDI, OP_DADDIU};
    send_word(itype(OP_SW, REG_SP, REG_RA, 16'h0000), 16'd0, 17'(DEEP_WORDS));
    for (i = 1; i < DEEP_WORDS - 3; i++)
      send_word(itype(adj_ops[i % 4], REG_SP, REG_SP, step_imm), 16'(i), 17'(DEEP_WORDS - i));
    send_word(rtype(REG_RA, FUNCT_JR), 16'(DEEP_WORDS - 3), 17'd3);
    send_word(32'h0, 16'(DEEP_WORDS - 2), 17'd2);
    send_word(32'h0, 16'(DEEP_WORDS - 1), 17'd1);
  endtask

  initial begin
    int n, waited;
    sb = new();
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: starts before any restart, then each decode path and boundary
    send_word(itype(OP_ADDIU, REG_SP, REG_SP, 16'hFFF8), 16'd7, 17'd9);
    send_word(32'h0, 16'd0, 17'd20);
    send_word(itype(OP_ADDIU, REG_SP, REG_SP, 16'h8000), 16'd1, 17'd19);
    send_word(itype(OP_SW, REG_SP, REG_RA, 16'h7FFC), 16'd2, 17'd18);
    send_word(itype(OP_DADDI, REG_SP, REG_SP, 16'h7FFF), 16'd3, 17'd17);
    send_word(itype(OP_SD, REG_SP, REG_RA, 16'hFFFC), 16'd4, 17'd16);
    send_word(itype(OP_ADDI, REG_SP, REG_SP, 16'h0000), 16'd5, 17'd15);
    send_word(rtype(REG_RA, FUNCT_JR), 16'd6, 17'd3);
    send_word(rtype(REG_RA, FUNCT_JR), 16'd7, 17'd14);
    send_word(itype(OP_LD, REG_SP, REG_RA, 16'h0008), 16'd8, 17'd13);
    send_word(itype(OP_LW, REG_SP, REG_RA, 16'h0000), 16'd9, 17'd12);
    send_word(itype(OP_DADDIU, REG_SP, REG_SP, 16'hFFF0), 16'd10, 17'd11);
    send_word(rtype(REG_RA, FUNCT_JR), 16'd11, 17'd2);
    send_word(itype(OP_ADDIU, REG_SP, 5'd8, 16'hFFF0), 16'd12, 17'd10);
    send_word(itype(OP_SW, 5'd8, REG_RA, 16'h0010), 16'd13, 17'd9);
    send_word(itype(OP_LW, REG_SP, 5'd30, 16'h0010), 16'd14, 17'd8);
    send_word(rtype(REG_RA, FUNCT_JALR), 16'd15, 17'd7);
    send_word(rtype(5'd25, FUNCT_JR), 16'd16, 17'd6);
    send_word(itype(OP_SWL, REG_SP, REG_RA, 16'h0004), 16'd17, 17'd5);
    send_word(32'h0, 16'd18, 17'd1);
    send_word(rtype(REG_RA, FUNCT_JR), 16'hFFFF, 17'd1);
    send_word(rtype(REG_RA, FUNCT_JR), 16'hFFFF, 17'h1FFFF);
    send_word(32'hFFFF_FFFF, 16'd0, 17'(MAX_REGION_WORDS));

    n = words_sent + RANDOM_WORDS;
    while (words_sent < n) begin
      idle_on = ($urandom_range(0, 3) != 0);
      if ($urandom_range(0, 4) == 0)
        repeat ($urandom_range(1, 4)) send_noise();
      else
        run_procedure($urandom_range(6, 24));
    end

    idle_on = 1'b1;
    run_deep_frame(16'h8000);

    idle_on = 1'b0;
    n = words_sent + QUIET_WORDS;
    while (words_sent < n) run_procedure($urandom_range(6, 16));

    @(negedge clk);
    in_valid <= 1'b0;
    waited = 0;
    while (sb.pending_intervals.size() != 0 && waited < 5000) begin
      @(posedge clk);
      waited++;
    end
    repeat (8) @(posedge clk);
    sb.flush_leftovers();
    if (sb.errors == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule
